### src/fla_pkg.sv
// Shared types and codes for the free-list range allocator.
// No dependencies; imported by the top level.
`default_nettype none
package fla_pkg;

  localparam logic [2:0] OP_ALLOC       = 3'd0;
  localparam logic [2:0] OP_ALLOC_RANGE = 3'd1;
  localparam logic [2:0] OP_FREE        = 3'd2;
  localparam logic [2:0] OP_RESERVE     = 3'd3;
  localparam logic [2:0] OP_ADD_REGION  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_PARTIAL = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_A1,
    S_A2,
    S_A3,
    S_CL1,
    S_CL2,
    S_F1,
    S_R1,
    S_R2,
    S_INS,
    S_IS_RD,
    S_IS_WR,
    S_IW0,
    S_IW1,
    S_DEL,
    S_DL_RD,
    S_DL_WR,
    S_CONT,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### src/fla_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module fla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### src/fla_align.sv
// Shared align-up unit: rounds an address up to a power-of-two boundary.
// No dependencies; the alignment input already holds a single set bit.
`default_nettype none
module fla_align #(
  parameter int AW = 32
) (
  input  wire logic [AW-1:0] x_i,
  input  wire logic [31:0]   align_i,
  output logic               ok_o,
  output logic [AW-1:0]      y_o
);

  localparam int XW = ((AW > 32) ? AW : 32) + 1;

  logic [XW-1:0] xe, ae, rem, add, lim, sum;

  always_comb begin
    xe  = XW'(x_i);
    ae  = XW'(align_i);
    rem = xe & (ae - XW'(1));
    add = ae - rem;
    lim = XW'({AW{1'b1}}) - xe;
    sum = xe + add;
    ok_o = (rem == '0) || !(add > lim);
    y_o  = (rem == '0) ? x_i : sum[AW-1:0];
  end

endmodule
`default_nettype wire

### src/free_list_range_allocator.sv
// Free-list range allocator: first-fit extent table with a sequencer.
// A scan reads the extents one at a time, and an insert or delete moves table
// entries one at a time, each read and then written back, through the single
// read port of the extent RAM. One item at a time.
// Reset clears count, free total and handshake state; the table RAM is not
// cleared, only entries below the count are ever read.
`default_nettype none
module free_list_range_allocator #(
  parameter int MAX_EXTENTS = 128,
  parameter int ADDR_WIDTH  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] end_address_i,
  input  wire logic [31:0] size_i,
  input  wire logic [31:0] align_i,
  input  wire logic [6:0]  slot_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      result_address_o,
  output logic [31:0]      free_bytes_o
);
  import fla_pkg::*;

  localparam int AW = ADDR_WIDTH;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);

  state_e state_q, state_d;

  // control state
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] total_q, total_d;
  logic          out_valid_q, out_valid_d;

  // item and scan registers
  logic [2:0]    op_q, op_d;
  logic [AW-1:0] addr_q, addr_d, end_q, end_d, size_q, size_d;
  logic [31:0]   al_q, al_d;
  logic [CW-1:0] i_q, i_d, p_q, p_d;
  logic [IW-1:0] j_q, j_d;
  logic [1:0]    st_q, st_d;
  logic [AW-1:0] res_q, res_d;
  logic [AW-1:0] b_q, b_d, l_q, l_d, a_q, a_d, take_q, take_d;
  logic [AW-1:0] pad_q, pad_d, rem_q, rem_d;
  logic [AW-1:0] w0b_q, w0b_d, w0l_q, w0l_d, w1b_q, w1b_d, w1l_q, w1l_d;
  logic          w1v_q, w1v_d;
  logic [1:0]    ost_q, ost_d;
  logic [31:0]   ores_q, ores_d, ofree_q, ofree_d;

  // extent RAM, entry = {length, base}
  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  logic [2*AW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]   rd_base, rd_len;

  fla_ram #(
    .WIDTH(2 * AW),
    .DEPTH(MAX_EXTENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_base = ram_rdata[AW-1:0];
  assign rd_len  = ram_rdata[2*AW-1:AW];

  // one align unit, shared between the extent base and the range start
  logic [AW-1:0] al_x, al_y;
  logic          al_ok;

  assign al_x = (state_q == S_A1) ? rd_base : addr_q;

  fla_align #(.AW(AW)) u_align (
    .x_i     (al_x),
    .align_i (al_q),
    .ok_o    (al_ok),
    .y_o     (al_y)
  );

  // input conversion
  logic [AW-1:0] in_addr, in_end, in_size;
  logic [31:0]   in_al_low;
  logic          slot_bad, full, acc, out_free;

  assign in_addr   = AW'(address_i);
  assign in_end    = AW'(end_address_i);
  assign in_size   = AW'(size_i);
  assign in_al_low = ((align_i & (~align_i + 32'd1)) == 32'd0) ? 32'd1
                   : (align_i & (~align_i + 32'd1));
  assign slot_bad  = ({25'd0, slot_index_i} >= 32'(MAX_EXTENTS));
  assign full      = (cnt_q >= MAXC);
  assign acc       = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // scan conditions
  logic [CW-1:0] nxt_i;
  logic          nxt_end, a2_below, a2_short, a3_bad, cl_miss, cl_split, cl_empty;
  logic [AW-1:0] cl_pad, r_d, r_avail;
  logic          f_c1, f_c2, f_c3, r_gap, r_above, r_past;
  logic [1:0]    st_fin;

  assign nxt_i    = i_q + CW'(1);
  assign nxt_end  = (nxt_i >= cnt_q);
  assign a2_below = (op_q == OP_ALLOC_RANGE) && (a_q < addr_q);
  assign a2_short = (l_q < (addr_q - b_q));
  assign a3_bad   = (op_q == OP_ALLOC_RANGE) && ((size_q > end_q) || (a_q > (end_q - size_q)));
  assign cl_pad   = a_q - b_q;
  assign cl_miss  = (a_q < b_q) || (cl_pad > l_q) || (take_q > (l_q - cl_pad));
  assign cl_split = (pad_q != '0) && (rem_q != '0);
  assign cl_empty = (pad_q == '0) && (rem_q == '0);
  assign f_c1     = (addr_q >= rd_base) && ((addr_q - rd_base) == rd_len);
  assign f_c2     = (rd_base >= addr_q) && ((rd_base - addr_q) == size_q);
  assign f_c3     = (addr_q < rd_base) || ((addr_q - rd_base) < rd_len);
  assign r_above  = (rd_base > addr_q);
  assign r_gap    = r_above && ((rd_base - addr_q) > size_q);
  assign r_d      = addr_q - b_q;
  assign r_past   = (r_d >= l_q);
  assign r_avail  = l_q - r_d;
  assign st_fin   = ((op_q == OP_RESERVE) && (st_q == ST_OK) && (size_q != '0)) ? ST_PARTIAL
                  : st_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (opcode_i)
            OP_ALLOC, OP_ALLOC_RANGE: state_d = (cnt_q == '0) ? S_DONE : S_RD;
            OP_FREE: begin
              if (in_size == '0) state_d = S_DONE;
              else if (cnt_q == '0) state_d = S_INS;
              else state_d = S_RD;
            end
            OP_RESERVE: state_d = ((in_size == '0) || (cnt_q == '0)) ? S_DONE : S_RD;
            OP_ADD_REGION: begin
              if (slot_bad || full || (in_size == '0)) state_d = S_DONE;
              else state_d = S_INS;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RD: begin
        case (op_q)
          OP_ALLOC, OP_ALLOC_RANGE: state_d = S_A1;
          OP_FREE: state_d = S_F1;
          OP_RESERVE: state_d = S_R1;
          default: state_d = S_DONE;
        endcase
      end
      S_A1: begin
        if (!al_ok) state_d = nxt_end ? S_DONE : S_RD;
        else state_d = S_A2;
      end
      S_A2: begin
        if (a2_below && a2_short) state_d = nxt_end ? S_DONE : S_RD;
        else if (a2_below && !al_ok) state_d = S_DONE;
        else state_d = S_A3;
      end
      S_A3: state_d = a3_bad ? S_DONE : S_CL1;
      S_CL1: begin
        if (cl_miss) state_d = nxt_end ? S_DONE : S_RD;
        else state_d = S_CL2;
      end
      S_CL2: begin
        if (cl_split && full) state_d = S_DONE;
        else if (cl_empty) state_d = S_DEL;
        else if (cl_split) state_d = S_INS;
        else state_d = S_CONT;
      end
      S_F1: begin
        if (f_c1 || f_c2) state_d = S_DONE;
        else if (f_c3 || nxt_end) state_d = full ? S_DONE : S_INS;
        else state_d = S_RD;
      end
      S_R1: state_d = r_gap ? S_DONE : S_R2;
      S_R2: begin
        if (r_past) state_d = ((size_q == '0) || nxt_end) ? S_DONE : S_RD;
        else state_d = S_CL1;
      end
      S_INS:   state_d = (p_q == cnt_q) ? S_IW0 : S_IS_RD;
      S_IS_RD: state_d = S_IS_WR;
      S_IS_WR: state_d = (CW'(j_q) == p_q) ? S_IW0 : S_IS_RD;
      S_IW0:   state_d = w1v_q ? S_IW1 : S_CONT;
      S_IW1:   state_d = S_CONT;
      S_DEL:   state_d = ((p_q + CW'(1)) >= cnt_q) ? S_CONT : S_DL_RD;
      S_DL_RD: state_d = S_DL_WR;
      S_DL_WR: state_d = ((CW'(j_q) + CW'(1)) == cnt_q) ? S_CONT : S_DL_RD;
      S_CONT: begin
        if ((op_q == OP_RESERVE) && (size_q != '0) && (i_q < cnt_q)) state_d = S_RD;
        else state_d = S_DONE;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    cnt_d = cnt_q; total_d = total_q;
    op_d = op_q; addr_d = addr_q; end_d = end_q; size_d = size_q; al_d = al_q;
    i_d = i_q; p_d = p_q; j_d = j_q; st_d = st_q; res_d = res_q;
    b_d = b_q; l_d = l_q; a_d = a_q; take_d = take_q; pad_d = pad_q; rem_d = rem_q;
    w0b_d = w0b_q; w0l_d = w0l_q; w1b_d = w1b_q; w1l_d = w1l_q; w1v_d = w1v_q;
    ost_d = ost_q; ores_d = ores_q; ofree_d = ofree_q;
    ram_we = 1'b0; ram_waddr = i_q[IW-1:0]; ram_wdata = '0;
    ram_re = 1'b0; ram_raddr = i_q[IW-1:0];
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          op_d = opcode_i; addr_d = in_addr; end_d = in_end; size_d = in_size;
          al_d = in_al_low; i_d = '0; res_d = '0; w1v_d = 1'b0;
          w0b_d = in_addr; w0l_d = in_size;
          st_d = ((opcode_i == OP_ALLOC) || (opcode_i == OP_ALLOC_RANGE)) ? ST_NO_FIT : ST_OK;
          if ((opcode_i == OP_FREE) && (in_size != '0) && (cnt_q == '0)) begin
            p_d = '0;
            total_d = total_q + in_size;
          end
          if (opcode_i == OP_ADD_REGION) begin
            if (slot_bad || full) begin
              st_d = ST_FULL;
            end else if (in_size != '0) begin
              p_d = ({25'd0, slot_index_i} > 32'(cnt_q)) ? cnt_q : CW'(slot_index_i);
              total_d = total_q + in_size;
            end
          end
        end
      end
      S_RD: ram_re = 1'b1;
      S_A1: begin
        b_d = rd_base; l_d = rd_len; a_d = al_y;
        if (!al_ok) i_d = nxt_i;
      end
      S_A2: begin
        if (a2_below) begin
          if (a2_short) i_d = nxt_i;
          else a_d = al_y;
        end
      end
      S_A3: take_d = size_q;
      S_CL1: begin
        if (cl_miss) begin
          i_d = nxt_i;
        end else begin
          pad_d = cl_pad;
          rem_d = l_q - cl_pad - take_q;
        end
      end
      S_CL2: begin
        if (cl_split && full) begin
          st_d = ST_FULL;
        end else begin
          total_d = total_q - take_q;
          if (op_q == OP_RESERVE) begin
            addr_d = addr_q + take_q;
            size_d = size_q - take_q;
          end else begin
            st_d = ST_OK;
            res_d = a_q;
          end
          p_d = i_q;
          if (cl_empty) begin
            i_d = i_q;
          end else if (pad_q == '0) begin
            // leading part taken: move the base up
            ram_we = 1'b1; ram_wdata = {rem_q, b_q + take_q};
            i_d = nxt_i;
          end else if (rem_q == '0) begin
            // trailing part taken: keep the padding
            ram_we = 1'b1; ram_wdata = {pad_q, b_q};
            i_d = nxt_i;
          end else begin
            w0b_d = b_q; w0l_d = pad_q;
            w1b_d = a_q + take_q; w1l_d = rem_q; w1v_d = 1'b1;
            i_d = i_q + CW'(2);
          end
        end
      end
      S_F1: begin
        if (f_c1) begin
          ram_we = 1'b1; ram_wdata = {rd_len + size_q, rd_base};
          total_d = total_q + size_q;
        end else if (f_c2) begin
          ram_we = 1'b1; ram_wdata = {rd_len + size_q, addr_q};
          total_d = total_q + size_q;
        end else if (f_c3 || nxt_end) begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            p_d = f_c3 ? i_q : cnt_q;
            total_d = total_q + size_q;
          end
        end else begin
          i_d = nxt_i;
        end
      end
      S_R1: begin
        b_d = rd_base; l_d = rd_len;
        if (r_gap) begin
          st_d = ST_PARTIAL;
        end else if (r_above) begin
          // skip the hole below this extent
          size_d = size_q - (rd_base - addr_q);
          addr_d = rd_base;
          st_d = ST_PARTIAL;
        end
      end
      S_R2: begin
        if (r_past) begin
          i_d = nxt_i;
        end else begin
          take_d = (size_q < r_avail) ? size_q : r_avail;
          a_d = addr_q;
        end
      end
      S_INS: if (p_q != cnt_q) j_d = IW'(cnt_q - CW'(1));
      S_IS_RD: begin
        ram_re = 1'b1; ram_raddr = j_q;
      end
      S_IS_WR: begin
        ram_we = 1'b1; ram_waddr = j_q + IW'(1); ram_wdata = ram_rdata;
        j_d = j_q - IW'(1);
      end
      S_IW0: begin
        ram_we = 1'b1; ram_waddr = p_q[IW-1:0]; ram_wdata = {w0l_q, w0b_q};
        cnt_d = cnt_q + CW'(1);
      end
      S_IW1: begin
        ram_we = 1'b1; ram_waddr = IW'(p_q + CW'(1)); ram_wdata = {w1l_q, w1b_q};
      end
      S_DEL: begin
        if ((p_q + CW'(1)) >= cnt_q) cnt_d = cnt_q - CW'(1);
        else j_d = IW'(p_q + CW'(1));
      end
      S_DL_RD: begin
        ram_re = 1'b1; ram_raddr = j_q;
      end
      S_DL_WR: begin
        ram_we = 1'b1; ram_waddr = j_q - IW'(1); ram_wdata = ram_rdata;
        if ((CW'(j_q) + CW'(1)) == cnt_q) cnt_d = cnt_q - CW'(1);
        else j_d = j_q + IW'(1);
      end
      S_CONT: ;
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ost_d   = st_fin;
          ores_d  = 32'(res_q);
          ofree_d = 32'(total_q);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; addr_q <= addr_d; end_q <= end_d; size_q <= size_d; al_q <= al_d;
    i_q <= i_d; p_q <= p_d; j_q <= j_d; st_q <= st_d; res_q <= res_d;
    b_q <= b_d; l_q <= l_d; a_q <= a_d; take_q <= take_d; pad_q <= pad_d; rem_q <= rem_d;
    w0b_q <= w0b_d; w0l_q <= w0l_d; w1b_q <= w1b_d; w1l_q <= w1l_d; w1v_q <= w1v_d;
    ost_q <= ost_d; ores_q <= ores_d; ofree_q <= ofree_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = ost_q;
  assign result_address_o = ores_q;
  assign free_bytes_o     = ofree_q;

endmodule
`default_nettype wire

### bench/fla_checker.sv
// Checker for the free-list range allocator: watches both channels, keeps a
// shadow extent table, predicts every result and compares it field by field.
// Depends on fla_pkg for opcode and status codes.
`timescale 1ns / 100ps
module fla_checker #(
  parameter int MAX_EXTENTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] end_address_i,
  input  logic [31:0] size_i,
  input  logic [31:0] align_i,
  input  logic [6:0]  slot_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] result_address_i,
  input  logic [31:0] free_bytes_i,
  output int          fail_count_o,
  output int          pending_o
);
  import fla_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [31:0] free_bytes;
  } alloc_result_t;

  logic [31:0] ext_base [MAX_EXTENTS];
  logic [31:0] ext_len  [MAX_EXTENTS];
  int unsigned ext_count;
  logic [31:0] free_sum;
  alloc_result_t expected_q[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic void insert_extent(int unsigned at, logic [31:0] b, logic [31:0] l);
    for (int j = ext_count; j > at; j--) begin
      ext_base[j] = ext_base[j-1];
      ext_len[j]  = ext_len[j-1];
    end
    ext_base[at] = b;
    ext_len[at]  = l;
    ext_count++;
  endfunction

  function automatic void delete_extent(int unsigned at);
    for (int unsigned j = at; j + 1 < ext_count; j++) begin
      ext_base[j] = ext_base[j+1];
      ext_len[j]  = ext_len[j+1];
    end
    ext_count--;
  endfunction

  // Round x up to the lowest set bit of al; returns 0 on overflow past the top.
  function automatic bit round_up(logic [31:0] x, logic [31:0] al, output logic [31:0] r);
    logic [32:0] a, rem, sum;
    a = {1'b0, al & (~al + 32'd1)};
    if (a == 0) a = 1;
    rem = {1'b0, x} & (a - 1);
    if (rem == 0) begin
      r = x;
      return 1;
    end
    sum = {1'b0, x} + (a - rem);
    if (sum[32]) return 0;
    r = sum[31:0];
    return 1;
  endfunction

  // Carve s bytes at a out of extent i; 0 done, 1 no fit, 2 table full.
  function automatic int carve(logic [31:0] a, logic [31:0] s, int unsigned i,
                               output int unsigned nx);
    logic [31:0] b, l, pad, rem;
    b = ext_base[i];
    l = ext_len[i];
    nx = i;
    if (a < b) return 1;
    pad = a - b;
    if (pad > l || s > l - pad) return 1;
    rem = l - pad - s;
    if (pad == 0) begin
      if (rem == 0) begin
        delete_extent(i);
        nx = i;
      end else begin
        ext_base[i] = b + s;
        ext_len[i]  = rem;
        nx = i + 1;
      end
    end else if (rem == 0) begin
      ext_len[i] = pad;
      nx = i + 1;
    end else begin
      if (ext_count >= MAX_EXTENTS) return 2;
      insert_extent(i, b, pad);
      ext_base[i+1] = a + s;
      ext_len[i+1]  = rem;
      nx = i + 2;
    end
    free_sum = free_sum - s;
    return 0;
  endfunction

  function automatic alloc_result_t apply_request(logic [2:0] op, logic [31:0] addr,
      logic [31:0] lim, logic [31:0] size, logic [31:0] al, logic [6:0] slot);
    alloc_result_t r;
    logic [31:0] a, b, l, take, avail;
    int unsigned nx, s;
    int rc, done;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ALLOC, OP_ALLOC_RANGE: begin
        r.status = ST_NO_FIT;
        for (int unsigned i = 0; i < ext_count; i++) begin
          if (!round_up(ext_base[i], al, a)) continue;
          if (op == OP_ALLOC_RANGE) begin
            if (a < addr) begin
              if (ext_len[i] < addr - ext_base[i]) continue;
              if (!round_up(addr, al, a)) break;
            end
            if (size > lim || a > lim - size) break;
          end
          rc = carve(a, size, i, nx);
          if (rc == 0) begin
            r.status = ST_OK;
            r.addr = a;
            break;
          end
          if (rc == 2) begin
            r.status = ST_FULL;
            break;
          end
        end
      end
      OP_FREE: begin
        if (size != 0) begin
          done = 0;
          for (int unsigned i = 0; i < ext_count && done == 0; i++) begin
            b = ext_base[i];
            l = ext_len[i];
            if (addr >= b && addr - b == l) begin
              ext_len[i] = l + size;
              done = 1;
            end else if (b >= addr && b - addr == size) begin
              ext_base[i] = addr;
              ext_len[i] = l + size;
              done = 1;
            end else if (addr < b || addr - b < l) begin
              if (ext_count >= MAX_EXTENTS) r.status = ST_FULL;
              else insert_extent(i, addr, size);
              done = 2;
            end
          end
          if (done == 0) begin
            if (ext_count >= MAX_EXTENTS) r.status = ST_FULL;
            else insert_extent(ext_count, addr, size);
          end
          if (r.status == ST_OK) free_sum = free_sum + size;
        end
      end
      OP_RESERVE: begin
        if (size != 0) begin
          s = 0;
          while (s < ext_count) begin
            b = ext_base[s];
            l = ext_len[s];
            if (b > addr && b - addr > size) begin
              r.status = ST_PARTIAL;
              break;
            end
            if (b > addr) begin
              size = size - (b - addr);
              addr = b;
              r.status = ST_PARTIAL;
            end
            if (addr - b >= l) begin
              if (size == 0) break;
              s++;
              continue;
            end
            avail = l - (addr - b);
            take = size < avail ? size : avail;
            rc = carve(addr, take, s, nx);
            if (rc == 2) begin
              r.status = ST_FULL;
              break;
            end
            addr = addr + take;
            size = size - take;
            s = nx;
            if (size == 0) break;
          end
          if (r.status == ST_OK && size != 0) r.status = ST_PARTIAL;
        end
      end
      OP_ADD_REGION: begin
        if (slot >= MAX_EXTENTS || ext_count >= MAX_EXTENTS) begin
          r.status = ST_FULL;
        end else if (size != 0) begin
          insert_extent(slot > ext_count ? ext_count : slot, addr, size);
          free_sum = free_sum + size;
        end
      end
      default: ;
    endcase
    r.free_bytes = free_sum;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      ext_count = 0;
      free_sum  = '0;
      fails     <= 0;
      expected_q.delete();
    end else begin
      // Compare the result first; a new request cannot produce it this edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected result status=%0d addr=%h free=%h",
                                   status_i, result_address_i, free_bytes_i);
        end else begin
          want = expected_q.pop_front();
          if (want.status !== status_i || want.addr !== result_address_i ||
              want.free_bytes !== free_bytes_i) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("mismatch: exp status=%0d addr=%h free=%h, got %0d %h %h",
                       want.status, want.addr, want.free_bytes,
                       status_i, result_address_i, free_bytes_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(apply_request(opcode_i, address_i, end_address_i,
                                           size_i, align_i, slot_index_i));
    end
  end

endmodule

### bench/tb_free_list_range_allocator.sv
// Top of the allocator bench: clock, reset, request stimulus and verdict.
// Depends on fla_pkg, the allocator RTL and fla_checker.
`timescale 1ns / 100ps
module tb_free_list_range_allocator;
  import fla_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [2:0]  opcode;
  logic [31:0] address, end_address, size, align;
  logic [6:0]  slot_index;
  logic        out_valid, out_stall;
  logic [1:0]  status;
  logic [31:0] result_address, free_bytes;
  int          fail_count, pending;
  bit          calm;  // no idling on either side near the end

  free_list_range_allocator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .address_i(address), .end_address_i(end_address),
    .size_i(size), .align_i(align), .slot_index_i(slot_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .result_address_o(result_address), .free_bytes_o(free_bytes)
  );

  fla_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .address_i(address), .end_address_i(end_address),
    .size_i(size), .align_i(align), .slot_index_i(slot_index),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .result_address_i(result_address),
    .free_bytes_i(free_bytes),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall in random bursts, with calm stretches between them.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hold the item until accepted; maybe idle for a burst afterwards.
  task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] e,
                              logic [31:0] s, logic [31:0] al, logic [6:0] sl);
    opcode <= op; address <= a; end_address <= e;
    size <= s; align <= al; slot_index <= sl;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Mostly small sizes and addresses inside a compact window, so that
  // allocations, frees and reserves hit the extents actually present.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return 32'h1000 + $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom();
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic logic [31:0] pick_align();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h1 << $urandom_range(0, 31);
      default: return 32'h1 << $urandom_range(0, 8);
    endcase
  endfunction

  initial begin
    logic [31:0] a, s;
    int watchdog;
    rst_n = 1'b0;
    calm = 1'b0;
    in_valid = 1'b0;
    opcode = OP_ALLOC; address = '0; end_address = '0;
    size = '0; align = 32'd1; slot_index = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, regions, each opcode and the corner cases.
    send_request(OP_ALLOC, 0, 0, 16, 1, 0);
    send_request(OP_RESERVE, 32'h100, 0, 16, 1, 0);
    send_request(OP_ADD_REGION, 32'h1_0000, 0, 32'h1_0000, 1, 0);
    send_request(OP_ADD_REGION, 32'h0, 0, 32'h100, 1, 7'd127);
    send_request(OP_ADD_REGION, 32'h8_0000, 0, 0, 1, 5);
    send_request(OP_ADD_REGION, 32'hFFFF_FF00, 0, 32'hFF, 1, 7'd100);
    send_request(OP_ALLOC, 0, 0, 32'h40, 32'h1000, 0);
    send_request(OP_ALLOC, 0, 0, 32'h10, 32'h0, 0);
    send_request(OP_ALLOC, 0, 0, 32'h10, 32'h18, 0);
    send_request(OP_ALLOC, 0, 0, 32'h10, 32'h8000_0000, 0);
    send_request(OP_ALLOC, 0, 0, 32'hFFFF_FFFF, 1, 0);
    send_request(OP_ALLOC_RANGE, 32'h1_8000, 32'h1_9000, 32'h100, 32'h100, 0);
    send_request(OP_ALLOC_RANGE, 32'h1_8000, 32'h1_8010, 32'h100, 1, 0);
    send_request(OP_ALLOC_RANGE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 4, 32'h8000_0000, 0);
    send_request(OP_FREE, 32'h1_8000, 0, 32'h100, 1, 0);
    send_request(OP_FREE, 32'h2_0000, 0, 32'h40, 1, 0);
    send_request(OP_FREE, 32'h3_0000, 0, 0, 1, 0);
    send_request(OP_FREE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 0);
    send_request(OP_RESERVE, 32'h1_0000, 0, 0, 1, 0);
    send_request(OP_RESERVE, 32'h1_4000, 0, 32'h100, 1, 0);
    send_request(OP_RESERVE, 32'h0F000, 0, 32'h1_8000, 1, 0);
    send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    send_request(3'd7, 0, 0, 0, 0, 0);

    // Fill the table to exercise the full-table paths, then carve it.
    for (int k = 0; k < 130; k++)
      send_request(OP_FREE, 32'h4000_0000 + k * 32'h100, 0, 32'h10, 1, 0);
    for (int k = 0; k < 8; k++)
      send_request(k[0] ? OP_ALLOC : OP_ADD_REGION, 32'h5000_0000, 0, 4, 32'h20, 7'h10);
    send_request(OP_RESERVE, 32'h4000_0004, 0, 4, 1, 0);
    send_request(OP_RESERVE, 32'h4000_0000, 0, 32'h1000, 1, 0);

    // Random: a mix of all opcodes, allocations most often, plus invalid codes.
    for (int n = 0; n < 640; n++) begin
      if (n == 560) calm = 1'b1;
      a = pick_addr();
      s = pick_size();
      case ($urandom_range(0, 9))
        0, 1, 2: send_request(OP_ALLOC, $urandom(), $urandom(), s, pick_align(),
                              7'($urandom()));
        3: send_request(OP_ALLOC_RANGE, a, a + $urandom_range(0, 32'h2_0000), s,
                        pick_align(), 7'($urandom()));
        4, 5: send_request(OP_FREE, a, $urandom(), s, $urandom(), 7'($urandom()));
        6: send_request(OP_RESERVE, a, $urandom(), s, $urandom(), 7'($urandom()));
        7, 8: send_request(OP_ADD_REGION, a, $urandom(), s, $urandom(),
                           7'($urandom_range(0, 9) == 0 ? $urandom()
                                                       : $urandom_range(0, 8)));
        default: send_request(3'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(),
                              $urandom(), 7'($urandom()));
      endcase
    end
    in_valid <= 1'b0;

    watchdog = 0;
    while (pending != 0 && watchdog < 200000) begin
      @(posedge clk);
      watchdog++;
    end
    repeat (50) @(posedge clk);
    if (pending == 0 && fail_count == 0)
      $display("tb_free_list_range_allocator: PASS");
    else
      $display("tb_free_list_range_allocator: FAIL");
    $finish;
  end

  // Worst case is roughly 800 items, each a reserve that empties and shifts
  // the whole table, plus the longest stalls.
  initial begin
    #1_000_000_000;
    $display("tb_free_list_range_allocator: FAIL");
    $finish;
  end

endmodule

### filelist.f
src/fla_pkg.sv
src/fla_ram.sv
src/fla_align.sv
src/free_list_range_allocator.sv
bench/fla_checker.sv
bench/tb_free_list_range_allocator.sv
